// File: src/jtc_pkg.sv
// ----------------------------------------------------------------------------
// jtc_pkg - joystick trim and calibrate conditioner package
// Shared widths, channel indexes, key operation codes, queue entry and
// result types.
// ----------------------------------------------------------------------------
package jtc_pkg;

   localparam int RAW_W   = 12;    // converter reading
   localparam int CH_W    = 10;    // conditioned level, 0..1000
   localparam int STEP_W  = 7;     // trim step register
   localparam int OFF_W   = 12;    // zero offset, signed
   localparam int TRIM_W  = 11;    // key trim, signed
   localparam int SUM_W   = 15;    // calibration sum, signed
   localparam int KEY_W   = 3;
   localparam int NUM_CH  = 4;
   localparam int Q_DEPTH = 2;

   localparam int FULL_SCALE = 1000;
   localparam int CENTRE     = 500;
   localparam int OFFSET_LIM = 2000;
   localparam int TRIM_LIM   = 1000;

   localparam int CH_THROTTLE = 0;
   localparam int CH_YAW      = 1;
   localparam int CH_PITCH    = 2;
   localparam int CH_ROLL     = 3;

   typedef enum logic [KEY_W-1:0] {
      KEY_NONE,
      KEY_PITCH_INC,
      KEY_PITCH_DEC,
      KEY_ROLL_DEC,
      KEY_ROLL_INC,
      KEY_SHUTDOWN,
      KEY_HOLD,
      KEY_CALIBRATE
   } key_op_type;

   typedef enum logic [1:0] {
      APPLY_IDLE,
      APPLY_MUL,
      APPLY_FIX
   } apply_state_type;

   // one queued item, levels already scaled
   typedef struct packed {
      logic                           is_key;
      key_op_type                     key_op;
      logic [NUM_CH-1:0][CH_W-1:0]    level;
   } entry_type;

   // one result item
   typedef struct packed {
      logic [NUM_CH-1:0][CH_W-1:0]    level;
      logic                           shutdown;
      logic                           hold_height;
      logic                           calibrating;
   } rsp_type;

endpackage

// File: src/jtc_front.sv
// ----------------------------------------------------------------------------
// jtc_front - request classification and scaling
// Accepts request transfers, decodes key codes and maps each reading to
// 1000 - raw*1000/4095 before the item enters the queue.
// ----------------------------------------------------------------------------
module jtc_front import jtc_pkg::*; (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [RAW_W-1:0]  req_raw_throttle,
   input  logic [RAW_W-1:0]  req_raw_yaw,
   input  logic [RAW_W-1:0]  req_raw_pitch,
   input  logic [RAW_W-1:0]  req_raw_roll,
   input  logic [KEY_W-1:0]  req_key_code,
   input  logic              q_full,
   output logic              push,
   output entry_type         push_entry
);

   localparam int PROD_W = RAW_W + 10;
   localparam int EST_W  = PROD_W + 1;

   // divide by 4095 = 2^12 - 1 exactly: (x + (x >> 12) + 1) >> 12
   function automatic logic [CH_W-1:0] scale_raw(input logic [RAW_W-1:0] raw);
      logic [PROD_W-1:0] prod;
      logic [EST_W-1:0]  est;
      logic [CH_W:0]     quo;
      prod = PROD_W'(raw) * PROD_W'(FULL_SCALE);
      est  = EST_W'(prod) + EST_W'(prod >> RAW_W) + EST_W'(1);
      quo  = est[EST_W-1:RAW_W];
      return CH_W'((CH_W+1)'(FULL_SCALE) - quo);
   endfunction

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      push_entry.is_key          = req_type;
      push_entry.key_op          = key_op_type'(req_key_code);
      push_entry.level[CH_THROTTLE] = scale_raw(req_raw_throttle);
      push_entry.level[CH_YAW]      = scale_raw(req_raw_yaw);
      push_entry.level[CH_PITCH]    = scale_raw(req_raw_pitch);
      push_entry.level[CH_ROLL]     = scale_raw(req_raw_roll);
   end

endmodule

// File: src/jtc_queue.sv
// ----------------------------------------------------------------------------
// jtc_queue - item queue between front and back
// Small first-in first-out store so that each side can stall on its own.
// ----------------------------------------------------------------------------
module jtc_queue import jtc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_entry,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output entry_type  head_entry
);

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   entry_type          mem_ff [Q_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("queue read while empty");

endmodule

// File: src/jtc_back.sv
// ----------------------------------------------------------------------------
// jtc_back - item execution
// Applies offsets and trims, clamps, runs key actions and the calibration
// run, and holds the result register.
// ----------------------------------------------------------------------------
module jtc_back import jtc_pkg::*; #(
   parameter int CAL_SAMPLES = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [STEP_W-1:0]  trim_step,
   input  logic               head_valid,
   input  entry_type          head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp
);

   localparam int REM_W     = $clog2(CAL_SAMPLES + 1);
   localparam int LVL_W     = 13;
   localparam int TC_W      = TRIM_W + 1;
   localparam int MAG_W     = SUM_W - 1;
   localparam int DIV_SHIFT = 16;
   localparam int RECIP     = (1 << DIV_SHIFT) / CAL_SAMPLES;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int PROD_W    = MAG_W + RECIP_W;
   localparam int QN_W      = MAG_W + 5;
   localparam int NEW_W     = SUM_W + 1;

   logic signed [OFF_W-1:0]   offset_ff [NUM_CH];
   logic signed [OFF_W-1:0]   offset_in [NUM_CH];
   logic signed [SUM_W-1:0]   sum_ff [NUM_CH];
   logic signed [SUM_W-1:0]   sum_in [NUM_CH];
   logic signed [TRIM_W-1:0]  pitch_trim_ff, pitch_trim_in;
   logic signed [TRIM_W-1:0]  roll_trim_ff, roll_trim_in;
   logic [REM_W-1:0]          cal_rem_ff, cal_rem_in;
   logic                      shutdown_ff, shutdown_in;
   logic                      hold_ff, hold_in;
   apply_state_type           apply_ff, apply_in;
   logic [MAG_W-1:0]          mag_ff [NUM_CH];
   logic [MAG_W-1:0]          mag_in [NUM_CH];
   logic                      neg_ff [NUM_CH];
   logic                      neg_in [NUM_CH];
   logic [PROD_W-1:0]         prod_ff [NUM_CH];
   logic [PROD_W-1:0]         prod_in [NUM_CH];
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   // per lane working values
   logic signed [LVL_W-1:0]   lvl_sum [NUM_CH];
   logic signed [LVL_W-1:0]   trim_add [NUM_CH];
   logic [CH_W-1:0]           lvl_clip [NUM_CH];
   logic signed [SUM_W-1:0]   sum_upd [NUM_CH];
   logic signed [SUM_W-1:0]   sum_abs [NUM_CH];
   logic [MAG_W-1:0]          quo [NUM_CH];
   logic [QN_W-1:0]           quo_n [NUM_CH];
   logic [MAG_W-1:0]          rem [NUM_CH];
   logic signed [NEW_W-1:0]   quo_s [NUM_CH];
   logic signed [NEW_W-1:0]   off_new [NUM_CH];
   logic signed [TC_W-1:0]    step_s;
   logic                      pop_sample;

   function automatic logic signed [TRIM_W-1:0] clamp_trim(input logic signed [TC_W-1:0] v);
      if (v > TC_W'(TRIM_LIM)) begin
         return TRIM_W'(TRIM_LIM);
      end else if (v < TC_W'(-TRIM_LIM)) begin
         return TRIM_W'(-TRIM_LIM);
      end
      return v[TRIM_W-1:0];
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // conditioning and division lanes
   always_comb begin
      step_s = TC_W'(signed'({1'b0, trim_step}));
      for (int i = 0; i < NUM_CH; i++) begin
         trim_add[i] = (i == CH_PITCH) ? LVL_W'(pitch_trim_ff) :
                       (i == CH_ROLL)  ? LVL_W'(roll_trim_ff)  : LVL_W'(0);
         lvl_sum[i]  = LVL_W'(signed'({1'b0, head_entry.level[i]})) - LVL_W'(offset_ff[i])
                       + trim_add[i];
         if (lvl_sum[i] < LVL_W'(0)) begin
            lvl_clip[i] = '0;
         end else if (lvl_sum[i] > LVL_W'(FULL_SCALE)) begin
            lvl_clip[i] = CH_W'(FULL_SCALE);
         end else begin
            lvl_clip[i] = lvl_sum[i][CH_W-1:0];
         end
         sum_upd[i] = sum_ff[i] + SUM_W'(signed'({1'b0, lvl_clip[i]}))
                      - ((i == CH_THROTTLE) ? SUM_W'(0) : SUM_W'(CENTRE));

         // reciprocal multiply on the magnitude of the sum
         sum_abs[i] = (sum_ff[i] < SUM_W'(0)) ? -sum_ff[i] : sum_ff[i];
         mag_in[i]  = sum_abs[i][MAG_W-1:0];
         neg_in[i]  = sum_ff[i][SUM_W-1];
         prod_in[i] = PROD_W'(mag_in[i]) * PROD_W'(RECIP);

         // estimate is low by at most one
         quo[i]   = MAG_W'(prod_ff[i] >> DIV_SHIFT);
         quo_n[i] = QN_W'(quo[i]) * QN_W'(CAL_SAMPLES);
         rem[i]   = mag_ff[i] - quo_n[i][MAG_W-1:0];
         if (rem[i] >= MAG_W'(CAL_SAMPLES)) begin
            quo[i] = quo[i] + MAG_W'(1);
         end
         quo_s[i] = NEW_W'(signed'({1'b0, quo[i]}));
         if (neg_ff[i]) begin
            quo_s[i] = -quo_s[i];
         end
         off_new[i] = NEW_W'(offset_ff[i]) + quo_s[i];
      end
   end

   // sequencing of items and the offset update
   always_comb begin
      apply_in      = apply_ff;
      offset_in     = offset_ff;
      sum_in        = sum_ff;
      pitch_trim_in = pitch_trim_ff;
      roll_trim_in  = roll_trim_ff;
      cal_rem_in    = cal_rem_ff;
      shutdown_in   = shutdown_ff;
      hold_in       = hold_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      pop           = 1'b0;
      pop_sample    = 1'b0;

      unique case (apply_ff)
         APPLY_IDLE: begin
            pop = head_valid && (head_entry.is_key || !rsp_valid_ff || rsp_ready);
         end
         APPLY_MUL: begin
            apply_in = APPLY_FIX;
         end
         APPLY_FIX: begin
            for (int i = 0; i < NUM_CH; i++) begin
               if (off_new[i] > NEW_W'(OFFSET_LIM)) begin
                  offset_in[i] = OFF_W'(OFFSET_LIM);
               end else if (off_new[i] < NEW_W'(-OFFSET_LIM)) begin
                  offset_in[i] = OFF_W'(-OFFSET_LIM);
               end else begin
                  offset_in[i] = off_new[i][OFF_W-1:0];
               end
               sum_in[i] = '0;
            end
            apply_in = APPLY_IDLE;
         end
         default: begin
            apply_in = APPLY_IDLE;
         end
      endcase

      if (pop && head_entry.is_key && cal_rem_ff == '0) begin
         unique case (head_entry.key_op)
            KEY_PITCH_INC: pitch_trim_in = clamp_trim(TC_W'(pitch_trim_ff) + step_s);
            KEY_PITCH_DEC: pitch_trim_in = clamp_trim(TC_W'(pitch_trim_ff) - step_s);
            KEY_ROLL_DEC:  roll_trim_in  = clamp_trim(TC_W'(roll_trim_ff) - step_s);
            KEY_ROLL_INC:  roll_trim_in  = clamp_trim(TC_W'(roll_trim_ff) + step_s);
            KEY_SHUTDOWN:  shutdown_in   = 1'b1;
            KEY_HOLD:      hold_in       = 1'b1;
            KEY_CALIBRATE: begin
               pitch_trim_in = '0;
               roll_trim_in  = '0;
               for (int i = 0; i < NUM_CH; i++) begin
                  sum_in[i] = '0;
               end
               cal_rem_in = REM_W'(CAL_SAMPLES);
            end
            KEY_NONE: begin
            end
            default: begin
            end
         endcase
      end

      if (pop && !head_entry.is_key) begin
         pop_sample = 1'b1;
         if (cal_rem_ff != '0) begin
            for (int i = 0; i < NUM_CH; i++) begin
               sum_in[i] = sum_upd[i];
            end
            cal_rem_in = cal_rem_ff - REM_W'(1);
            if (cal_rem_ff == REM_W'(1)) begin
               apply_in = APPLY_MUL;
            end
         end
         for (int i = 0; i < NUM_CH; i++) begin
            rsp_in.level[i] = lvl_clip[i];
         end
         rsp_in.shutdown    = shutdown_ff;
         rsp_in.hold_height = hold_ff;
         rsp_in.calibrating = (cal_rem_in != '0);
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            offset_ff[i] <= '0;
            sum_ff[i]    <= '0;
         end
         pitch_trim_ff <= '0;
         roll_trim_ff  <= '0;
         cal_rem_ff    <= '0;
         shutdown_ff   <= 1'b0;
         hold_ff       <= 1'b0;
         apply_ff      <= APPLY_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         offset_ff     <= offset_in;
         sum_ff        <= sum_in;
         pitch_trim_ff <= pitch_trim_in;
         roll_trim_ff  <= roll_trim_in;
         cal_rem_ff    <= cal_rem_in;
         shutdown_ff   <= shutdown_in;
         hold_ff       <= hold_in;
         apply_ff      <= apply_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   a_trims_clear_while_cal: assert property (@(posedge clock) disable iff (reset)
      (cal_rem_ff != '0) |-> (pitch_trim_ff == '0 && roll_trim_ff == '0))
      else $error("trim non-zero during calibration run");

   a_last_sample_applies: assert property (@(posedge clock) disable iff (reset)
      (pop_sample && cal_rem_ff == REM_W'(1)) |=> (apply_ff == APPLY_MUL))
      else $error("offset update not started after last calibration sample");

   a_offsets_in_range: assert property (@(posedge clock) disable iff (reset)
      (apply_ff == APPLY_FIX) |=>
         (offset_ff[CH_THROTTLE] <= OFF_W'(OFFSET_LIM) &&
          offset_ff[CH_THROTTLE] >= OFF_W'(-OFFSET_LIM) &&
          offset_ff[CH_ROLL] <= OFF_W'(OFFSET_LIM) &&
          offset_ff[CH_ROLL] >= OFF_W'(-OFFSET_LIM) &&
          sum_ff[CH_YAW] == '0 && cal_rem_ff == '0))
      else $error("offset update left state out of range");

endmodule

// File: src/joystick_trim_calibrate_conditioner.sv
// ----------------------------------------------------------------------------
// joystick_trim_calibrate_conditioner - stick conditioning with trims
// Top level: trim step register, request front end, item queue and back end.
// ----------------------------------------------------------------------------
// Two kinds of request transfer come in: stick samples (req_type 0) and key
// events (req_type 1). Each sample gives exactly one response transfer with
// the four levels 1000 - raw*1000/4095, less the zero offset, plus the key
// trim on pitch and roll, clamped to 0..1000, together with the sticky
// shutdown and hold-height flags and the calibrating flag. Key events give no
// response; they step the trims by the csr trim step, set the sticky flags or
// start a calibration run, and are dropped while a run is collecting. The
// block takes one item per clock while the queue is not full: the front end
// scales the readings and the item waits in a two-entry queue, so a new
// request is taken while a result still waits in the response register. The
// back end pops a sample from the queue head and registers its levels in the
// response register, which then holds it valid. Once a run has collected its
// last sample, the back end moves the offsets by the mean in the states
// APPLY_MUL (a reciprocal multiply) and APPLY_FIX (one correction step) and
// takes nothing from the queue during them; the queue soaks up up to two
// requests. The trim step may only be written while no item is in flight.
// ----------------------------------------------------------------------------
module joystick_trim_calibrate_conditioner import jtc_pkg::*; #(
   parameter int CAL_SAMPLES = 10
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [RAW_W-1:0]  req_raw_throttle,
   input  logic [RAW_W-1:0]  req_raw_yaw,
   input  logic [RAW_W-1:0]  req_raw_pitch,
   input  logic [RAW_W-1:0]  req_raw_roll,
   input  logic [KEY_W-1:0]  req_key_code,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CH_W-1:0]   rsp_throttle_out,
   output logic [CH_W-1:0]   rsp_yaw_out,
   output logic [CH_W-1:0]   rsp_pitch_out,
   output logic [CH_W-1:0]   rsp_roll_out,
   output logic              rsp_shutdown_req,
   output logic              rsp_hold_height_req,
   output logic              rsp_calibrating,
   // trim step register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [STEP_W-1:0] csr_trim_step
);

   localparam logic [STEP_W-1:0] TRIM_STEP_RESET = STEP_W'(10);

   logic [STEP_W-1:0] trim_step_ff, trim_step_in;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_head_valid;
   entry_type         q_push_entry;
   entry_type         q_head_entry;
   rsp_type           rsp_data;

   // register port is always free, a write lands at the transfer edge
   assign csr_ready    = 1'b1;
   assign trim_step_in = (csr_valid && csr_ready) ? csr_trim_step : trim_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_step_ff <= TRIM_STEP_RESET;
      end else begin
         trim_step_ff <= trim_step_in;
      end
   end

   // scaling and key decode before the queue
   jtc_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_raw_throttle (req_raw_throttle),
      .req_raw_yaw      (req_raw_yaw),
      .req_raw_pitch    (req_raw_pitch),
      .req_raw_roll     (req_raw_roll),
      .req_key_code     (req_key_code),
      .q_full           (q_full),
      .push             (q_push),
      .push_entry       (q_push_entry)
   );

   // decouples request acceptance from back-end stalls
   jtc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   // offsets, trims, calibration run and response register
   jtc_back #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .trim_step  (trim_step_ff),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp_data)
   );

   assign rsp_throttle_out    = rsp_data.level[CH_THROTTLE];
   assign rsp_yaw_out         = rsp_data.level[CH_YAW];
   assign rsp_pitch_out       = rsp_data.level[CH_PITCH];
   assign rsp_roll_out        = rsp_data.level[CH_ROLL];
   assign rsp_shutdown_req    = rsp_data.shutdown;
   assign rsp_hold_height_req = rsp_data.hold_height;
   assign rsp_calibrating     = rsp_data.calibrating;

endmodule

// File: bench/jtc_checker.sv
// ----------------------------------------------------------------------------
// jtc_checker - response checker for the joystick conditioner
// Watches the request, response and trim step channels, keeps its own copy of
// offsets, trims, flags and calibration sums, and compares every response
// transfer with the oldest predicted stick levels and flags.
// ----------------------------------------------------------------------------
module jtc_checker import jtc_pkg::*; #(
   parameter int CAL_SAMPLES = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_type,
   input  logic [RAW_W-1:0]  req_raw_throttle,
   input  logic [RAW_W-1:0]  req_raw_yaw,
   input  logic [RAW_W-1:0]  req_raw_pitch,
   input  logic [RAW_W-1:0]  req_raw_roll,
   input  logic [KEY_W-1:0]  req_key_code,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [CH_W-1:0]   rsp_throttle_out,
   input  logic [CH_W-1:0]   rsp_yaw_out,
   input  logic [CH_W-1:0]   rsp_pitch_out,
   input  logic [CH_W-1:0]   rsp_roll_out,
   input  logic              rsp_shutdown_req,
   input  logic              rsp_hold_height_req,
   input  logic              rsp_calibrating,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [STEP_W-1:0] csr_trim_step,
   output int                fail_count,
   output int                outstanding
);

   localparam int ADC_MAX = 4095;

   logic [STEP_W-1:0]        trim_step_q;
   logic signed [OFF_W-1:0]  zero_offset [NUM_CH];
   logic signed [TRIM_W-1:0] pitch_trim;
   logic signed [TRIM_W-1:0] roll_trim;
   logic signed [SUM_W-1:0]  cal_sum [NUM_CH];
   logic [4:0]               cal_left;
   logic                     shutdown_flag;
   logic                     hold_flag;
   rsp_type                  stick_levels_q [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // full deflection reads as zero, rest as full scale
   function automatic int scale_reading(logic [RAW_W-1:0] raw);
      return FULL_SCALE - (int'(raw) * FULL_SCALE) / ADC_MAX;
   endfunction

   task automatic clear_state();
      trim_step_q   = 7'd10;
      pitch_trim    = '0;
      roll_trim     = '0;
      cal_left      = '0;
      shutdown_flag = 1'b0;
      hold_flag     = 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
         zero_offset[i] = '0;
         cal_sum[i]     = '0;
      end
   endtask

   task automatic apply_key(key_op_type op);
      int step;
      step = int'(trim_step_q);
      // keys are dropped while a calibration run collects
      if (cal_left != 0) return;
      case (op)
         KEY_PITCH_INC:
            pitch_trim = TRIM_W'(clamp(int'(pitch_trim) + step, -TRIM_LIM, TRIM_LIM));
         KEY_PITCH_DEC:
            pitch_trim = TRIM_W'(clamp(int'(pitch_trim) - step, -TRIM_LIM, TRIM_LIM));
         KEY_ROLL_DEC:
            roll_trim  = TRIM_W'(clamp(int'(roll_trim) - step, -TRIM_LIM, TRIM_LIM));
         KEY_ROLL_INC:
            roll_trim  = TRIM_W'(clamp(int'(roll_trim) + step, -TRIM_LIM, TRIM_LIM));
         KEY_SHUTDOWN: shutdown_flag = 1'b1;
         KEY_HOLD:     hold_flag     = 1'b1;
         KEY_CALIBRATE: begin
            pitch_trim = '0;
            roll_trim  = '0;
            for (int i = 0; i < NUM_CH; i++) cal_sum[i] = '0;
            cal_left = 5'(CAL_SAMPLES);
         end
         default: ;
      endcase
   endtask

   task automatic condition_sample(input logic [RAW_W-1:0] th, ya, pi, ro,
                                   output rsp_type res);
      int               level [NUM_CH];
      logic [RAW_W-1:0] raw [NUM_CH];
      raw = '{th, ya, pi, ro};
      for (int i = 0; i < NUM_CH; i++)
         level[i] = scale_reading(raw[i]) - int'(zero_offset[i]);
      level[CH_PITCH] += int'(pitch_trim);
      level[CH_ROLL]  += int'(roll_trim);
      for (int i = 0; i < NUM_CH; i++)
         level[i] = clamp(level[i], 0, FULL_SCALE);
      if (cal_left != 0) begin
         for (int i = 0; i < NUM_CH; i++)
            cal_sum[i] = SUM_W'(int'(cal_sum[i]) + level[i]
                                - (i == CH_THROTTLE ? 0 : CENTRE));
         cal_left = cal_left - 1'b1;
         // last sample of the run: move offsets by the truncated mean
         if (cal_left == 0) begin
            for (int i = 0; i < NUM_CH; i++) begin
               zero_offset[i] = OFF_W'(clamp(int'(zero_offset[i])
                                             + int'(cal_sum[i]) / CAL_SAMPLES,
                                             -OFFSET_LIM, OFFSET_LIM));
               cal_sum[i] = '0;
            end
         end
      end
      for (int i = 0; i < NUM_CH; i++)
         res.level[i] = CH_W'(level[i]);
      res.shutdown    = shutdown_flag;
      res.hold_height = hold_flag;
      res.calibrating = (cal_left != 0);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_state();
         stick_levels_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            trim_step_q = csr_trim_step;
         if (rsp_valid && rsp_ready) begin
            if (stick_levels_q.size() == 0) begin
               $error("response transfer with no sample outstanding");
               fail_count++;
            end else begin
               want = stick_levels_q.pop_front();
               check_field("throttle_out", want.level[CH_THROTTLE], rsp_throttle_out);
               check_field("yaw_out", want.level[CH_YAW], rsp_yaw_out);
               check_field("pitch_out", want.level[CH_PITCH], rsp_pitch_out);
               check_field("roll_out", want.level[CH_ROLL], rsp_roll_out);
               check_field("shutdown_req", want.shutdown, rsp_shutdown_req);
               check_field("hold_height_req", want.hold_height, rsp_hold_height_req);
               check_field("calibrating", want.calibrating, rsp_calibrating);
            end
         end
         if (req_valid && req_ready) begin
            // req_type high marks a key event
            if (req_type) begin
               apply_key(key_op_type'(req_key_code));
            end else begin
               condition_sample(req_raw_throttle, req_raw_yaw, req_raw_pitch,
                                req_raw_roll, want);
               stick_levels_q.push_back(want);
            end
         end
      end
      outstanding = stick_levels_q.size();
   end

endmodule

// File: bench/joystick_trim_calibrate_conditioner_tb.sv
// ----------------------------------------------------------------------------
// joystick_trim_calibrate_conditioner_tb - regression bench for the conditioner
// Drives a short directed run and then random sample, key and calibration
// sequences over several trim step settings and idling patterns; the checker
// beside the block predicts and compares every response transfer.
// ----------------------------------------------------------------------------
module joystick_trim_calibrate_conditioner_tb;
   import jtc_pkg::*;

   localparam int CAL_SAMPLES    = 10;
   localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
   localparam int SETTLE_CYCLES  = 12;    // key items and offset update in flight
   localparam int DRAIN_CYCLES   = 20;    // look for stray responses at the end

   // request kinds on req_type
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_KEY    = 1'b1;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_type;
   logic [RAW_W-1:0]  req_raw_throttle;
   logic [RAW_W-1:0]  req_raw_yaw;
   logic [RAW_W-1:0]  req_raw_pitch;
   logic [RAW_W-1:0]  req_raw_roll;
   logic [KEY_W-1:0]  req_key_code;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [CH_W-1:0]   rsp_throttle_out;
   logic [CH_W-1:0]   rsp_yaw_out;
   logic [CH_W-1:0]   rsp_pitch_out;
   logic [CH_W-1:0]   rsp_roll_out;
   logic              rsp_shutdown_req;
   logic              rsp_hold_height_req;
   logic              rsp_calibrating;
   logic              csr_valid;
   logic              csr_ready;
   logic [STEP_W-1:0] csr_trim_step;

   int send_idle_pct;   // chance per cycle that the sender holds back
   int rsp_idle_pct;    // chance per cycle that the receiver stalls
   int fail_count;
   int outstanding;     // samples still waiting for their response
   int quiet_cycles;

   always #5 clock = ~clock;

   joystick_trim_calibrate_conditioner #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_raw_throttle    (req_raw_throttle),
      .req_raw_yaw         (req_raw_yaw),
      .req_raw_pitch       (req_raw_pitch),
      .req_raw_roll        (req_raw_roll),
      .req_key_code        (req_key_code),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_throttle_out    (rsp_throttle_out),
      .rsp_yaw_out         (rsp_yaw_out),
      .rsp_pitch_out       (rsp_pitch_out),
      .rsp_roll_out        (rsp_roll_out),
      .rsp_shutdown_req    (rsp_shutdown_req),
      .rsp_hold_height_req (rsp_hold_height_req),
      .rsp_calibrating     (rsp_calibrating),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_trim_step       (csr_trim_step)
   );

   jtc_checker #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_raw_throttle    (req_raw_throttle),
      .req_raw_yaw         (req_raw_yaw),
      .req_raw_pitch       (req_raw_pitch),
      .req_raw_roll        (req_raw_roll),
      .req_key_code        (req_key_code),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_throttle_out    (rsp_throttle_out),
      .rsp_yaw_out         (rsp_yaw_out),
      .rsp_pitch_out       (rsp_pitch_out),
      .rsp_roll_out        (rsp_roll_out),
      .rsp_shutdown_req    (rsp_shutdown_req),
      .rsp_hold_height_req (rsp_hold_height_req),
      .rsp_calibrating     (rsp_calibrating),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_trim_step       (csr_trim_step),
      .fail_count          (fail_count),
      .outstanding         (outstanding)
   );

   // receiver back-pressure, redrawn every falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // one request transfer; valid stays up from one item to the next unless
   // the sender decides to idle, and the task returns on the accepting edge
   task automatic send_item(logic kind, logic [RAW_W-1:0] th, ya, pi, ro,
                            logic [KEY_W-1:0] key);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_raw_throttle <= th;
      req_raw_yaw      <= ya;
      req_raw_pitch    <= pi;
      req_raw_roll     <= ro;
      req_key_code     <= key;
      do @(posedge clock); while (!req_ready);
   endtask

   // unused key code still carries random bits
   task automatic send_sample(logic [RAW_W-1:0] th, ya, pi, ro);
      send_item(REQ_SAMPLE, th, ya, pi, ro, KEY_W'($urandom_range(7)));
   endtask

   // readings are don't-care on key items, so fill them with noise
   task automatic send_key(key_op_type op);
      send_item(REQ_KEY, RAW_W'($urandom_range(4095)), RAW_W'($urandom_range(4095)),
                RAW_W'($urandom_range(4095)), RAW_W'($urandom_range(4095)), op);
   endtask

   // readings bunch at the stops and round the centre, where clamping and
   // calibration have the most to do
   function automatic logic [RAW_W-1:0] random_raw();
      case ($urandom_range(4))
         0:       return '0;
         1:       return '1;
         2:       return RAW_W'($urandom_range(2098, 1998));
         default: return RAW_W'($urandom_range(4095));
      endcase
   endfunction

   task automatic send_random_sample();
      send_sample(random_raw(), random_raw(), random_raw(), random_raw());
   endtask

   // trim step writes happen only with nothing in flight: drain the responses,
   // then give trailing key items and any offset update time to settle
   task automatic write_trim_step(logic [STEP_W-1:0] step);
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid     <= 1'b1;
      csr_trim_step <= step;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed traffic: plain samples, single keys, runs of one trim
   // key that reach the trim limit at the larger trim steps, and calibration
   // runs with stray keys mixed in that the block has to drop
   task automatic run_random(int count);
      int         sent;
      int         pick;
      key_op_type op;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_random_sample();
            sent++;
         end else if (pick < 80) begin
            send_key(key_op_type'($urandom_range(6)));
            sent++;
         end else if (pick < 90) begin
            op = key_op_type'($urandom_range(KEY_ROLL_INC, KEY_PITCH_INC));
            repeat (12) send_key(op);
            send_random_sample();
            sent += 13;
         end else begin
            send_key(KEY_CALIBRATE);
            sent++;
            for (int i = 0; i < CAL_SAMPLES; i++) begin
               if ($urandom_range(5) == 0) begin
                  send_key(key_op_type'($urandom_range(7)));
                  sent++;
               end
               send_random_sample();
               sent++;
            end
         end
      end
   endtask

   // watchdog: ends the run if no transfer on any channel for too long
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_SAMPLE;
      req_raw_throttle = '0;
      req_raw_yaw      = '0;
      req_raw_pitch    = '0;
      req_raw_roll     = '0;
      req_key_code     = KEY_NONE;
      rsp_ready        = 1'b0;
      csr_valid        = 1'b0;
      csr_trim_step    = '0;
      send_idle_pct    = 28;
      rsp_idle_pct     = 72;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: stops and centre, every key, sticky flags, then a full
      // calibration run with keys that must be ignored, all at the reset step
      send_sample('0, '0, '0, '0);
      send_sample('1, '1, '1, '1);
      send_sample(RAW_W'(1), RAW_W'(4094), RAW_W'(2047), RAW_W'(2048));
      send_key(KEY_NONE);
      send_key(KEY_PITCH_INC);
      send_key(KEY_PITCH_DEC);
      send_key(KEY_ROLL_DEC);
      send_key(KEY_ROLL_INC);
      send_key(KEY_PITCH_INC);
      send_key(KEY_ROLL_DEC);
      send_sample(RAW_W'(2048), RAW_W'(2048), RAW_W'(2048), RAW_W'(2048));
      send_key(KEY_SHUTDOWN);
      send_key(KEY_HOLD);
      send_sample('1, '0, '0, '1);
      send_key(KEY_CALIBRATE);
      for (int i = 0; i < CAL_SAMPLES; i++) begin
         if (i == 3) send_key(KEY_PITCH_INC);
         if (i == 6) send_key(KEY_CALIBRATE);
         send_sample(RAW_W'(i * 400), RAW_W'(4095 - i * 400), RAW_W'(1000),
                     RAW_W'(3000));
      end
      send_sample(RAW_W'(2048), RAW_W'(2048), RAW_W'(2048), RAW_W'(2048));

      // sender mostly busy, receiver mostly stalled
      write_trim_step('1);
      run_random(300);
      write_trim_step('0);
      run_random(250);

      // the other way round
      send_idle_pct = 72;
      rsp_idle_pct  = 28;
      write_trim_step(STEP_W'(1));
      run_random(300);
      write_trim_step(STEP_W'(100));
      run_random(300);

      // back to back on both sides
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      write_trim_step(STEP_W'($urandom_range(99, 2)));
      run_random(350);

      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
src/jtc_pkg.sv
src/jtc_front.sv
src/jtc_queue.sv
src/jtc_back.sv
src/joystick_trim_calibrate_conditioner.sv
bench/jtc_checker.sv
bench/joystick_trim_calibrate_conditioner_tb.sv
